>>> rtl/assert_macros.svh
// Assertion macros for the RTL; the line classifier includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define AT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define AT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/at_rlc_pkg.sv
// Types and constants of the AT response line classifier.
package at_rlc_pkg;

  localparam int LINE_BYTES_DEFAULT    = 32;
  localparam int URC_SLOTS_DEFAULT     = 4;
  localparam int URC_MAX_BYTES_DEFAULT = 8;

  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int RECENT_W     = 64;
  localparam int CLASS_W      = 2;
  localparam int SLOT_W       = 2;
  localparam int LENGTH_W     = 5;
  localparam int COUNT_REG_W  = 3;
  localparam int NIBBLE_W     = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_URC_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_A = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTHS   = 3'd5;

  // characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_VT    = 8'h0b;
  localparam logic [7:0] CHAR_FF    = 8'h0c;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;

  // tails, oldest byte in the high bits
  localparam logic [15:0] TAIL_OK        = 16'h4f4b;        // "OK"
  localparam logic [23:0] TAIL_SP_OK     = 24'h204f4b;      // " OK"
  localparam logic [39:0] TAIL_ERROR     = 40'h4552524f52;  // "ERROR"
  localparam logic [31:0] TAIL_ERR_COLON = 32'h4552523a;    // "ERR:"

  typedef enum logic [CLASS_W-1:0] {
    CLASS_URC          = 2'd0,
    CLASS_OK           = 2'd1,
    CLASS_ERROR        = 2'd2,
    CLASS_INTERMEDIATE = 2'd3
  } line_class_t;

  typedef struct packed {
    line_class_t         line_class;
    logic [SLOT_W-1:0]   slot;
    logic [LENGTH_W-1:0] length;
  } result_t;

endpackage

>>> rtl/at_response_line_classifier.sv
// AT response line classifier: splits modem bytes into lines and classifies each line.
//
// Channels: rx_byte comes in on in_valid/in_stall, one byte per item. Each
// line end (CR or LF) of a line with text gives one result item on
// out_valid/out_stall: line_class, urc_slot and text_length. Bytes that do
// not end a line, and line ends of lines with no text (empty, blanks only), give no item.
// Throughput: one byte per cycle while in_stall is low. All matching for a
// byte (prefix windows of every slot, OK and error tails) is combinational
// compare logic in front of the line state registers and the result register.
// Results: a line's result is registered into the output register when its
// line end byte is accepted, or into the skid register while the receiver stalls.
// Stall: the output register is backed by a one-item skid register. While
// the receiver stalls, bytes keep flowing; in_stall goes high only once a
// second result waits behind the stalled one, and drops when it moves up.
// Reset (rst, synchronous): clears the line state, both output slots and the
// configuration registers (no prefixes in use, all lengths zero).
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock
// edge; unknown indexes are ignored. Write only while the block is idle.
`include "assert_macros.svh"

module at_response_line_classifier #(
  parameter int LINE_BYTES    = at_rlc_pkg::LINE_BYTES_DEFAULT,
  parameter int URC_SLOTS     = at_rlc_pkg::URC_SLOTS_DEFAULT,
  parameter int URC_MAX_BYTES = at_rlc_pkg::URC_MAX_BYTES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [at_rlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [at_rlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [at_rlc_pkg::CLASS_W-1:0]     line_class,
  output logic [at_rlc_pkg::SLOT_W-1:0]      urc_slot,
  output logic [at_rlc_pkg::LENGTH_W-1:0]    text_length
);
  import at_rlc_pkg::*;

  localparam int CW = $clog2(LINE_BYTES);          // fill and text counters
  localparam int PB = URC_MAX_BYTES * 8;           // stored prefix bits
  localparam logic [CW-1:0] FILL_MAX = CW'(LINE_BYTES - 1);

  // ---------------- configuration registers ----------------
  logic [COUNT_REG_W-1:0] urc_count;
  logic [PB-1:0]          urc_pattern [URC_SLOTS];
  logic [NIBBLE_W-1:0]    urc_len     [URC_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      urc_count <= '0;
      for (int s = 0; s < URC_SLOTS; s++) begin
        urc_pattern[s] <= '0;
        urc_len[s]     <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_URC_COUNT) begin
        urc_count <= cfg_data[COUNT_REG_W-1:0];
      end
      for (int s = 0; s < URC_SLOTS; s++) begin
        if (cfg_index == REG_PATTERN_A + CFG_INDEX_W'(s)) begin
          urc_pattern[s] <= cfg_data[PB-1:0];
        end
        if (cfg_index == REG_LENGTHS) begin
          urc_len[s] <= cfg_data[NIBBLE_W*s +: NIBBLE_W];
        end
      end
    end
  end

  // Effective prefix length: clamped, and cut at the first zero byte.
  function automatic logic [NIBBLE_W-1:0] eff_len(logic [NIBBLE_W-1:0] n,
                                                  logic [PB-1:0] pat);
    logic [NIBBLE_W-1:0] lim;
    logic [NIBBLE_W-1:0] r;
    logic                done;
    lim  = (n > NIBBLE_W'(URC_MAX_BYTES)) ? NIBBLE_W'(URC_MAX_BYTES) : n;
    r    = lim;
    done = 1'b0;
    for (int i = 0; i < URC_MAX_BYTES; i++) begin
      if (!done && NIBBLE_W'(i) < lim && pat[8*i +: 8] == CHAR_NUL) begin
        r    = NIBBLE_W'(i);
        done = 1'b1;
      end
    end
    return r;
  endfunction

  // Newest len text bytes equal the prefix (first prefix byte is oldest).
  function automatic logic tail_hit(logic [RECENT_W-1:0] recent, logic [CW-1:0] cnt,
                                    logic [PB-1:0] pat, logic [NIBBLE_W-1:0] len);
    logic ok;
    int   idx;
    ok = (len != '0) && (int'(cnt) >= int'(len));
    for (int i = 0; i < URC_MAX_BYTES; i++) begin
      idx = (NIBBLE_W'(i) < len) ? (int'(len) - 1 - i) : 0;
      if (NIBBLE_W'(i) < len && pat[8*i +: 8] != recent[8*idx +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  logic [NIBBLE_W-1:0] slot_len [URC_SLOTS];

  always_comb begin
    for (int s = 0; s < URC_SLOTS; s++) begin
      slot_len[s] = eff_len(urc_len[s], urc_pattern[s]);
    end
  end

  // ---------------- line state ----------------
  logic [CW-1:0]        fill_count, fill_count_next;
  logic                 text_started, text_started_next;
  logic                 zero_seen, zero_seen_next;
  logic [CW-1:0]        stripped_count, stripped_count_next;
  logic [7:0]           first_text_char, first_text_char_next;
  logic [RECENT_W-1:0]  recent_bytes, recent_bytes_next;
  logic [URC_SLOTS-1:0] urc_hit_flags, urc_hit_flags_next;
  logic                 error_hit, error_hit_next;

  logic    in_fire;
  logic    is_eol;
  logic    is_blank;
  logic    res_valid;
  result_t line_res;

  assign in_fire  = in_valid && !in_stall;
  assign is_eol   = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
  assign is_blank = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
                    (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);

  always_comb begin
    fill_count_next      = fill_count;
    text_started_next    = text_started;
    zero_seen_next       = zero_seen;
    stripped_count_next  = stripped_count;
    first_text_char_next = first_text_char;
    recent_bytes_next    = recent_bytes;
    urc_hit_flags_next   = urc_hit_flags;
    error_hit_next       = error_hit;
    if (is_eol) begin
      fill_count_next      = '0;
      text_started_next    = 1'b0;
      zero_seen_next       = 1'b0;
      stripped_count_next  = '0;
      first_text_char_next = '0;
      recent_bytes_next    = '0;
      urc_hit_flags_next   = '0;
      error_hit_next       = 1'b0;
    end else if (fill_count != FILL_MAX) begin
      // overlong bytes are dropped but do not end the line
      fill_count_next = fill_count + 1'b1;
      if (zero_seen) begin
        // text after a NUL is ignored
      end else if (rx_byte == CHAR_NUL) begin
        zero_seen_next = 1'b1;
      end else if (!text_started && is_blank) begin
        // leading whitespace skipped
      end else begin
        if (!text_started) begin
          first_text_char_next = rx_byte;
        end
        text_started_next   = 1'b1;
        recent_bytes_next   = {recent_bytes[RECENT_W-9:0], rx_byte};
        stripped_count_next = stripped_count + 1'b1;
        for (int s = 0; s < URC_SLOTS; s++) begin
          if (tail_hit(recent_bytes_next, stripped_count_next, urc_pattern[s],
                       slot_len[s])) begin
            urc_hit_flags_next[s] = 1'b1;
          end
        end
        if ((stripped_count_next >= CW'(5) && recent_bytes_next[39:0] == TAIL_ERROR) ||
            (stripped_count_next >= CW'(4) && recent_bytes_next[31:0] == TAIL_ERR_COLON)) begin
          error_hit_next = 1'b1;
        end
      end
    end
  end

  // Classification at line end, from the state before the CR/LF.
  always_comb begin
    logic [COUNT_REG_W-1:0] used;
    logic                   found;
    logic [SLOT_W-1:0]      slot;
    logic                   ok_exact;
    logic                   ok_tail;
    line_class_t            cls;
    used  = (urc_count > COUNT_REG_W'(URC_SLOTS)) ? COUNT_REG_W'(URC_SLOTS) : urc_count;
    found = 1'b0;
    slot  = '0;
    for (int s = 0; s < URC_SLOTS; s++) begin
      if (!found && COUNT_REG_W'(s) < used && (urc_hit_flags[s] || slot_len[s] == '0)) begin
        found = 1'b1;
        slot  = SLOT_W'(s);
      end
    end
    ok_exact = (stripped_count == CW'(2)) && (recent_bytes[15:0] == TAIL_OK);
    ok_tail  = (first_text_char == CHAR_PLUS) && (stripped_count > CW'(3)) &&
               (recent_bytes[23:0] == TAIL_SP_OK);
    priority if (found) begin
      cls = CLASS_URC;
    end else if (ok_exact || ok_tail) begin
      cls = CLASS_OK;
    end else if (error_hit) begin
      cls = CLASS_ERROR;
    end else begin
      cls = CLASS_INTERMEDIATE;
    end
    line_res.line_class = cls;
    line_res.slot       = slot;
    line_res.length     = LENGTH_W'(stripped_count);
  end

  assign res_valid = in_fire && is_eol && (fill_count != '0) && (stripped_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count      <= '0;
      text_started    <= 1'b0;
      zero_seen       <= 1'b0;
      stripped_count  <= '0;
      first_text_char <= '0;
      recent_bytes    <= '0;
      urc_hit_flags   <= '0;
      error_hit       <= 1'b0;
    end else if (in_fire) begin
      fill_count      <= fill_count_next;
      text_started    <= text_started_next;
      zero_seen       <= zero_seen_next;
      stripped_count  <= stripped_count_next;
      first_text_char <= first_text_char_next;
      recent_bytes    <= recent_bytes_next;
      urc_hit_flags   <= urc_hit_flags_next;
      error_hit       <= error_hit_next;
    end
  end

  // ---------------- output register and skid ----------------
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        if (res_valid) begin
          out_res <= line_res;
        end
      end
    end else if (res_valid) begin
      skid_res   <= line_res;
      skid_valid <= 1'b1;
    end
  end

  assign in_stall    = skid_valid;
  assign line_class  = out_res.line_class;
  assign urc_slot    = out_res.slot;
  assign text_length = out_res.length;

  // ---------------- assertions ----------------
  `AT_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> out_valid,
             "skid register full while output register empty")
  `AT_ASSERT(a_started_matches_count, clk, rst, text_started == (stripped_count != '0),
             "text start flag disagrees with text count")
  `AT_ASSERT(a_text_within_fill, clk, rst, stripped_count <= fill_count,
             "text count exceeds kept byte count")
  `AT_ASSERT(a_fill_limit, clk, rst, fill_count <= FILL_MAX,
             "kept byte count beyond line limit")
  `AT_ASSERT_NEXT(a_eol_clears, clk, rst, in_fire && is_eol,
                  fill_count == '0 && urc_hit_flags == '0 && !error_hit,
                  "line state not cleared after line end")

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the AT response line classifier.
`timescale 1ns / 1ps

module testbench;
  import at_rlc_pkg::*;

  localparam int LINE_BYTES    = LINE_BYTES_DEFAULT;
  localparam int URC_SLOTS     = URC_SLOTS_DEFAULT;
  localparam int URC_MAX_BYTES = URC_MAX_BYTES_DEFAULT;
  localparam int RUN_LIMIT     = 400000;   // watchdog limit, in cycles
  localparam int CHUNK_BYTES   = 28;       // live random bytes per register setting
  localparam logic [7:0] NUL_MARK = 8'h7e; // '~' in a table row stands for a zero byte

  // ---------------------------------------------------------------------------
  // DUT and its ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [7:0]             rx_byte   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CLASS_W-1:0]     line_class;
  logic [SLOT_W-1:0]      urc_slot;
  logic [LENGTH_W-1:0]    text_length;

  at_response_line_classifier #(
    .LINE_BYTES   (LINE_BYTES),
    .URC_SLOTS    (URC_SLOTS),
    .URC_MAX_BYTES(URC_MAX_BYTES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_class (line_class),
    .urc_slot   (urc_slot),
    .text_length(text_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the registers and of the line state
  // ---------------------------------------------------------------------------
  logic [COUNT_REG_W-1:0] slots_used = '0;
  logic [63:0]            prefix_pat [4] = '{default: '0};
  logic [15:0]            prefix_len = '0;

  int          kept_bytes  = 0;   // bytes of the line kept so far (max LINE_BYTES-1)
  int          text_bytes  = 0;   // visible text after leading blanks
  bit          text_begun  = 1'b0;
  bit          nul_seen    = 1'b0;
  bit          error_seen  = 1'b0;
  logic [7:0]  lead_char   = '0;
  logic [63:0] tail_window = '0;  // newest text byte in bits 7..0
  logic [3:0]  prefix_hits = '0;

  result_t expected_lines [$];    // classes still owed by the DUT, oldest first

  int mismatches    = 0;
  int live_bytes    = 0;          // bytes that touched the line state
  int send_gap_pct  = 0;          // sender idles this often (percent)
  int stall_pct     = 0;          // receiver stalls this often (percent)
  int unsigned cycle_count = 0;

  logic [7:0] line_bytes [$];     // random line under construction
  logic [7:0] blanks [4] = '{CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF};
  string      prefix_words [] = '{"RING", "+CMTI:", "+CREG:", "NO CARR", "+QIURC",
                                  "CONNECT", "+CSQ", "SEND OK"};

  // first byte in bits 7..0, as the pattern registers hold it
  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] v;
    int i;
    v = '0;
    for (i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // Usable prefix length: nibble capped at URC_MAX_BYTES, cut at the first zero byte.
  function automatic int prefix_length(input int s);
    int n, i;
    n = prefix_len[4*s +: 4];
    if (n > URC_MAX_BYTES) n = URC_MAX_BYTES;
    for (i = 0; i < n; i++)
      if (prefix_pat[s][8*i +: 8] == 8'h00) return i;
    return n;
  endfunction

  function automatic bit text_ends_with(input logic [63:0] pat, input int len);
    int i;
    if (text_bytes < len) return 1'b0;
    for (i = 0; i < len; i++)
      if (tail_window[8*(len-1-i) +: 8] != pat[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] v);
    if (idx == REG_URC_COUNT)
      slots_used = v[COUNT_REG_W-1:0];
    else if (idx == REG_LENGTHS)
      prefix_len = v[15:0];
    else if (idx >= REG_PATTERN_A && idx < REG_PATTERN_A + 4)
      prefix_pat[idx - REG_PATTERN_A] = v;
    // anything else is an unused index: no effect
  endfunction

  // Advance the shadow line state by one accepted byte. Returns 1 when the byte
  // closes a non-empty line; cls then holds the class owed. live is 0 for bytes
  // the block drops (past the line limit or after a zero byte).
  function automatic bit classify_byte(input logic [7:0] c, output result_t cls,
                                       output bit live);
    int  used, s, len;
    bit  emit, found;
    cls  = '0;
    live = 1'b1;
    emit = 1'b0;
    if (c == CHAR_LF || c == CHAR_CR) begin
      if (kept_bytes > 0 && text_bytes > 0) begin
        emit = 1'b1;
        cls.line_class = CLASS_INTERMEDIATE;
        cls.length     = LENGTH_W'(text_bytes);
        // slot count is read here, at the line end, capped at URC_SLOTS
        used  = (slots_used > URC_SLOTS) ? URC_SLOTS : slots_used;
        found = 1'b0;
        for (s = 0; s < used; s++)
          if (!found && (prefix_hits[s] || prefix_length(s) == 0)) begin
            // an empty prefix matches every line
            found          = 1'b1;
            cls.line_class = CLASS_URC;
            cls.slot       = SLOT_W'(s);
          end
        if (!found) begin
          if ((text_bytes == 2 && tail_window[15:0] == TAIL_OK) ||
              (lead_char == CHAR_PLUS && text_bytes > 3 &&
               tail_window[23:0] == TAIL_SP_OK))
            cls.line_class = CLASS_OK;
          else if (error_seen)
            cls.line_class = CLASS_ERROR;
        end
      end
      kept_bytes  = 0;
      text_bytes  = 0;
      text_begun  = 1'b0;
      nul_seen    = 1'b0;
      error_seen  = 1'b0;
      lead_char   = '0;
      tail_window = '0;
      prefix_hits = '0;
      return emit;
    end
    if (kept_bytes >= LINE_BYTES - 1) begin
      live = 1'b0;            // overlong line: dropped, but the line goes on
      return 1'b0;
    end
    kept_bytes++;
    if (nul_seen) begin
      live = 1'b0;
      return 1'b0;
    end
    if (c == CHAR_NUL)
      nul_seen = 1'b1;
    else if (!text_begun &&
             (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF))
      return 1'b0;            // leading blank
    else begin
      if (!text_begun) lead_char = c;
      text_begun  = 1'b1;
      tail_window = {tail_window[55:0], c};
      text_bytes++;
      // prefix hits use the registers in force as this byte arrives
      for (s = 0; s < URC_SLOTS; s++) begin
        len = prefix_length(s);
        if (len > 0 && text_ends_with(prefix_pat[s], len)) prefix_hits[s] = 1'b1;
      end
      if ((text_bytes >= 5 && tail_window[39:0] == TAIL_ERROR) ||
          (text_bytes >= 4 && tail_window[31:0] == TAIL_ERR_COLON))
        error_seen = 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // One byte item: optional idle cycles, then hold it until accepted. When
  // typed is set, a line end owes the typed class instead of the predicted one.
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    result_t got;
    bit      emit, live;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    emit = classify_byte(b, got, live);
    if (emit) expected_lines.push_back(typed ? want : got);
    if (live) live_bytes++;
  endtask

  // Drop valid and wait until every owed class has come back, then wait for
  // a byte still moving through the line state.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all eight indexes in a row; count and length registers carry junk
  // in their unused high bits, indexes past the length register are unused.
  task automatic load_setting(input logic [COUNT_REG_W-1:0] count,
                              input logic [63:0] pa, pb, pc, pd,
                              input logic [15:0] lens);
    logic [CFG_DATA_W-1:0] vals [1 << CFG_INDEX_W];
    int i;
    for (i = 0; i < (1 << CFG_INDEX_W); i++) vals[i] = {$urandom, $urandom};
    vals[REG_URC_COUNT][COUNT_REG_W-1:0] = count;
    vals[REG_PATTERN_A]                  = pa;
    vals[REG_PATTERN_A + 1]              = pb;
    vals[REG_PATTERN_A + 2]              = pc;
    vals[REG_PATTERN_A + 3]              = pd;
    vals[REG_LENGTHS][15:0]              = lens;
    for (i = 0; i < (1 << CFG_INDEX_W); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      apply_register(CFG_INDEX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_setting();
    logic [63:0] pat [4];
    logic [15:0] lens;
    string       w;
    int          s, pick;
    for (s = 0; s < 4; s++) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        w      = prefix_words[$urandom_range(prefix_words.size() - 1)];
        pat[s] = pack_text(w);
        // a length past the word runs into zero bytes and is cut there
        lens[4*s +: 4] = 4'(w.len() + (($urandom_range(3) == 0) ? $urandom_range(1, 7) : 0));
      end else begin
        pat[s] = {$urandom, $urandom};
        lens[4*s +: 4] = (pick < 9) ? 4'($urandom_range(1, 15)) : 4'd0;
      end
    end
    load_setting(COUNT_REG_W'($urandom_range(7)), pat[0], pat[1], pat[2], pat[3], lens);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic add_printable(input int n);
    repeat (n) line_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
  endtask

  // One random line: mostly well-formed modem responses with random content,
  // some noise, overlong and empty lines.
  task automatic random_line();
    int kind, n, s, i;
    line_bytes.delete();
    kind = $urandom_range(99);
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) line_bytes.push_back(blanks[$urandom_range(3)]);
    if (kind < 18) begin
      add_text("OK");
      if ($urandom_range(3) == 0) add_printable($urandom_range(1, 3));  // near miss
    end else if (kind < 32) begin
      if ($urandom_range(4) != 0) add_text("+");
      add_printable($urandom_range(0, 6));
      add_text(" OK");
    end else if (kind < 46) begin
      add_printable($urandom_range(0, 6));
      case ($urandom_range(2))
        0:       add_text("ERROR");
        1:       add_text("ERR:");
        default: add_text("ERRO");
      endcase
      add_printable($urandom_range(0, 4));
    end else if (kind < 66) begin
      add_printable($urandom_range(0, 4));
      s = $urandom_range(3);
      n = prefix_length(s);
      if (n > 1 && $urandom_range(3) == 0) n--;      // broken prefix
      for (i = 0; i < n; i++) line_bytes.push_back(prefix_pat[s][8*i +: 8]);
      add_printable($urandom_range(0, 4));
    end else if (kind < 80) begin
      add_printable($urandom_range(1, 12));
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 10)) line_bytes.push_back(8'($urandom_range(255)));
    end else if (kind < 96) begin
      add_printable($urandom_range(28, 40));
      if ($urandom_range(1) == 0) add_text("OK");
    end
    if (line_bytes.size() > 0 && $urandom_range(15) == 0)
      line_bytes.insert($urandom_range(line_bytes.size()), CHAR_NUL);
    case ($urandom_range(2))
      0:       line_bytes.push_back(CHAR_CR);
      1:       line_bytes.push_back(CHAR_LF);
      default: begin
        line_bytes.push_back(CHAR_CR);
        line_bytes.push_back(CHAR_LF);
      end
    endcase
    foreach (line_bytes[i]) send_byte(line_bytes[i], 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tables: one line per row, then its line end byte
  // ---------------------------------------------------------------------------
  typedef struct {
    string      text;
    logic [7:0] term;
    bit         typed;
    result_t    want;
  } line_row_t;

  // registers as after reset: no prefixes in use
  line_row_t reset_rows [] = '{
    '{"OK",                  CHAR_CR, 1'b1, '{CLASS_OK,           2'd0, 5'd2}},
    '{"",                    CHAR_LF, 1'b0, '0},  // empty line
    '{"\011\013\014 ERROR",  CHAR_LF, 1'b1, '{CLASS_ERROR,        2'd0, 5'd5}},
    '{"  ",                  CHAR_CR, 1'b0, '0},  // blanks only
    '{"+C: 1 OK",            CHAR_CR, 1'b1, '{CLASS_OK,           2'd0, 5'd8}},
    '{"ERR:",                CHAR_LF, 1'b1, '{CLASS_ERROR,        2'd0, 5'd4}},
    '{"A~ERROR",             CHAR_CR, 1'b1, '{CLASS_INTERMEDIATE, 2'd0, 5'd1}},
    '{"\001\377",            CHAR_LF, 1'b1, '{CLASS_INTERMEDIATE, 2'd0, 5'd2}},
    '{"xxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxOK",
                             CHAR_CR, 1'b1, '{CLASS_INTERMEDIATE, 2'd0, 5'd31}}
  };

  // count 7 (capped), slot 1 length 12 (capped), slot 2 cut by a zero byte,
  // slot 3 empty so that it takes every line the others miss
  line_row_t urc_rows [] = '{
    '{"RING",                CHAR_CR, 1'b1, '{CLASS_URC, 2'd0, 5'd4}},
    '{"+CMTI: \"SM\",3",     CHAR_LF, 1'b1, '{CLASS_URC, 2'd1, 5'd13}},
    '{"+CSQ: 9",             CHAR_CR, 1'b1, '{CLASS_URC, 2'd2, 5'd7}},
    '{"OK",                  CHAR_CR, 1'b1, '{CLASS_URC, 2'd3, 5'd2}}
  };

  task automatic walk_rows(input line_row_t rows []);
    int r, i;
    logic [7:0] c;
    for (r = 0; r < rows.size(); r++) begin
      for (i = 0; i < rows[r].text.len(); i++) begin
        c = rows[r].text[i];
        send_byte((c == NUL_MARK) ? CHAR_NUL : c, rows[r].typed, rows[r].want);
      end
      send_byte(rows[r].term, rows[r].typed, rows[r].want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall, compare each accepted item with the oldest owed
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected item: class %0d slot %0d length %0d",
                 $time, line_class, urc_slot, text_length);
        mismatches++;
      end else begin
        want = expected_lines.pop_front();
        if (line_class !== want.line_class) begin
          $display("%0t: line_class expected %0d got %0d", $time, want.line_class, line_class);
          mismatches++;
        end
        if (urc_slot !== want.slot) begin
          $display("%0t: urc_slot expected %0d got %0d", $time, want.slot, urc_slot);
          mismatches++;
        end
        if (text_length !== want.length) begin
          $display("%0t: text_length expected %0d got %0d", $time, want.length, text_length);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase, chunk;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 34;
    stall_pct    = 83;
    walk_rows(reset_rows);

    settle();
    load_setting(3'd7, pack_text("RING"), pack_text("+CMTI: \""),
                 pack_text("+C") | (64'h41 << 24), pack_text("BUSY"), 16'h06c4);
    walk_rows(urc_rows);

    // Registers change in the middle of a line: the hit on "RING" is judged
    // with the new prefix, the slot count at the line end.
    send_byte("x", 1'b0, '0);
    send_byte("R", 1'b0, '0);
    send_byte("I", 1'b0, '0);
    settle();
    load_setting(3'd1, pack_text("RING"), '0, '0, '0, 16'h0004);
    send_byte("N", 1'b0, '0);
    send_byte("G", 1'b0, '0);
    send_byte(CHAR_CR, 1'b0, '0);

    // Random part: three idling profiles, three register settings each.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_gap_pct = 34; stall_pct = 83; end
        1:       begin send_gap_pct = 83; stall_pct = 34; end
        default: begin send_gap_pct = 0;  stall_pct = 0;  end
      endcase
      for (chunk = 0; chunk < 3; chunk++) begin
        settle();
        if (phase == 0 && chunk == 0)
          load_setting(3'd7, '1, '1, '1, '1, 16'hffff);
        else if (phase == 1 && chunk == 0)
          load_setting(3'd0, '0, '0, '0, '0, 16'h0000);
        else if (phase == 2 && chunk == 0)
          load_setting(3'd4, pack_text("RING"), pack_text("+CREG:"), pack_text("+QIURC"),
                       pack_text("NO CARR"), 16'h7664);
        else
          random_setting();
        live_bytes = 0;
        while (live_bytes < CHUNK_BYTES) random_line();
      end
    end

    settle();
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
